>>> hdl/lpsr_pkg.sv
`default_nettype none

package lpsr_pkg;

  localparam int unsigned ValueW         = 32;
  localparam int unsigned LenW           = 17;
  localparam int unsigned MaxLengthDef   = 65536;
  localparam int unsigned SearchStepsDef = 17;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic [LenW-1:0] best_length;
    logic            end_of_sequence;
    logic            overflow;
  } out_word_t;

endpackage

`default_nettype wire

>>> hdl/longest_positive_sum_run.sv
// Result path: a word past the depth limit goes straight to the emit state; otherwise the
//   prefix sum is compared with the stack top and pushed if not above it, or a binary search runs
//   (probe inside the stack: one memory read and one compare; probe above the top: no read),
//   then the run is measured before the emit state; a stalled output adds its stall.
// Input: ready again once the sequencer is idle, also while the previous result still waits.
//   Reset clears the control and sum registers, not the stack memory, search registers or output data.
`default_nettype none

module longest_positive_sum_run #(
  parameter int unsigned MAX_LENGTH   = lpsr_pkg::MaxLengthDef,
  parameter int unsigned SEARCH_STEPS = lpsr_pkg::SearchStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpsr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpsr_pkg::out_word_t out_data_o
);
  import lpsr_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_LENGTH + 1);
  localparam int unsigned HW    = $clog2(MAX_LENGTH + 2);
  localparam int unsigned SW    = ValueW + PW;
  localparam int unsigned CW    = ((HW > SEARCH_STEPS) ? HW : SEARCH_STEPS) + 1;
  localparam int unsigned KW    = $clog2(SEARCH_STEPS);
  localparam int unsigned Depth = MAX_LENGTH + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCmp  = 3'd1;
  localparam logic [2:0] StAddr = 3'd2;
  localparam logic [2:0] StTest = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StRun  = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  typedef struct packed {
    logic [PW-1:0]        pos;
    logic signed [SW-1:0] total;
  } entry_t;

  logic [2:0]           state_q, state_d;
  logic signed [SW-1:0] prefix_q, prefix_d;
  logic signed [SW-1:0] top_q, top_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [HW-1:0]        height_q, height_d;
  logic [PW-1:0]        best_q, best_d;
  logic                 last_q, last_d;
  logic                 over_q, over_d;
  logic [CW-1:0]        c_q, c_d;
  logic [CW-1:0]        cand_q, cand_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 rd_zero_q, rd_zero_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  entry_t               mem [Depth];
  entry_t               rd_q;
  logic                 mem_we, mem_re;
  logic [PW-1:0]        mem_wa, mem_ra;
  entry_t               mem_wd;

  logic [CW-1:0]        step, cand, c_clamp;
  logic                 cand_ok, at_limit, out_free;
  logic signed [SW-1:0] value_ext, rd_total;
  logic [PW-1:0]        rd_pos, run;

  assign step      = CW'(1) << k_q;
  assign cand      = c_q + step;
  assign cand_ok   = cand <= CW'(height_q);
  assign c_clamp   = (c_q >= CW'(height_q)) ? CW'(height_q) - CW'(1) : c_q;
  assign at_limit  = pos_q >= PW'(MAX_LENGTH);
  assign out_free  = !out_valid_q || out_ready_i;
  assign value_ext = SW'(in_data_i.value);
  // entry zero is the implicit base: position zero, sum zero
  assign rd_total  = rd_zero_q ? '0 : rd_q.total;
  assign rd_pos    = rd_zero_q ? '0 : rd_q.pos;
  assign run       = pos_q - rd_pos;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    top_d       = top_q;
    pos_d       = pos_q;
    height_d    = height_q;
    best_d      = best_q;
    last_d      = last_q;
    over_d      = over_q;
    c_d         = c_q;
    cand_d      = cand_q;
    k_d         = k_q;
    rd_zero_d   = rd_zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = height_q[PW-1:0];
    mem_wd      = '{pos: pos_q, total: prefix_q};
    mem_re      = 1'b0;
    mem_ra      = PW'(cand - CW'(1));

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          last_d = in_data_i.last;
          if (at_limit) begin
            over_d  = 1'b1;
            state_d = StEmit;
          end else begin
            over_d   = 1'b0;
            pos_d    = pos_q + PW'(1);
            prefix_d = prefix_q + value_ext;
            state_d  = StCmp;
          end
        end
      end
      StCmp: begin
        if (top_q >= prefix_q) begin
          // push unless the stack is full
          if (height_q < HW'(MAX_LENGTH + 1)) begin
            mem_we   = 1'b1;
            top_d    = prefix_q;
            height_d = height_q + HW'(1);
          end
          state_d = StEmit;
        end else begin
          c_d     = '0;
          k_d     = KW'(SEARCH_STEPS - 1);
          state_d = StAddr;
        end
      end
      StAddr: begin
        cand_d = cand;
        if (cand_ok) begin
          mem_re    = 1'b1;
          rd_zero_d = (cand == CW'(1));
          state_d   = StTest;
        end else if (k_q == '0) begin
          state_d = StFin;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      StTest: begin
        if (rd_total >= prefix_q) begin
          c_d = cand_q;
        end
        if (k_q == '0) begin
          state_d = StFin;
        end else begin
          k_d     = k_q - KW'(1);
          state_d = StAddr;
        end
      end
      StFin: begin
        mem_re    = 1'b1;
        mem_ra    = PW'(c_clamp);
        rd_zero_d = (c_clamp == '0);
        state_d   = StRun;
      end
      StRun: begin
        if (run > best_q) begin
          best_d = run;
        end
        state_d = StEmit;
      end
      StEmit: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.best_length     = LenW'(best_q);
          out_d.end_of_sequence = last_q;
          out_d.overflow        = over_q;
          if (last_q) begin
            prefix_d = '0;
            top_d    = '0;
            pos_d    = '0;
            height_d = HW'(1);
            best_d   = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prefix_q    <= '0;
      top_q       <= '0;
      pos_q       <= '0;
      height_q    <= HW'(1);
      best_q      <= '0;
      last_q      <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      top_q       <= top_d;
      pos_q       <= pos_d;
      height_q    <= height_d;
      best_q      <= best_d;
      last_q      <= last_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    cand_q    <= cand_d;
    k_q       <= k_d;
    rd_zero_q <= rd_zero_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lpsr_checker.sv
`default_nettype none

module lpsr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire lpsr_pkg::in_word_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lpsr_pkg::out_word_t out_data_o
);
  import lpsr_pkg::*;

  logic            in_acc, out_acc;
  logic [1:0]      pending_q;
  logic [LenW-1:0] prev_best_q;
  logic            prev_end_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // words taken but whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      prev_best_q <= '0;
      prev_end_q  <= 1'b1;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        prev_best_q <= out_data_o.best_length;
        prev_end_q  <= out_data_o.end_of_sequence;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o && !$rose(out_valid_o))
    else $error("ready or result right after taking a word");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("more than two words outstanding");

  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !prev_end_q |-> out_data_o.best_length >= prev_best_q)
    else $error("best length shrank within a sequence");

endmodule

bind longest_positive_sum_run lpsr_checker u_lpsr_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import lpsr_pkg::*;

  localparam int unsigned Depth         = MaxLengthDef;
  localparam int unsigned Steps         = SearchStepsDef;
  localparam int unsigned SearchLatency = 2 * Steps + 5;
  localparam longint      CycleLimit    = 20_000_000;

  typedef enum int {
    STYLE_SMALL,
    STYLE_FULL,
    STYLE_DRIFT,
    STYLE_EXTREME
  } value_style_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  longint cycle_count     = 0;
  int     mismatches      = 0;
  int     words_sent      = 0;
  int     sequences_sent  = 0;
  int     overflow_words  = 0;
  int     results_checked = 0;
  int     longest_seen    = 0;
  int     stall_left      = 0;
  bit     tx_idle_on      = 1'b1;
  bit     rx_idle_on      = 1'b1;

  // run tracker: prefix sum plus stack of non-increasing prefix sums
  longint      run_prefix;
  int unsigned run_pos;
  int unsigned run_height;
  int unsigned run_best;
  longint      sum_stack [0:Depth];
  int unsigned pos_stack [0:Depth];
  out_word_t   pending_lengths [$];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  longest_positive_sum_run #(
    .MAX_LENGTH  (Depth),
    .SEARCH_STEPS(Steps)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  function automatic void clear_tracker();
    run_prefix   = 0;
    run_pos      = 0;
    run_height   = 1;
    run_best     = 0;
    sum_stack[0] = 0;
    pos_stack[0] = 0;
  endfunction

  function automatic out_word_t track_run(in_word_t w);
    out_word_t   r;
    longint      v;
    int unsigned c;
    int unsigned stride;
    int unsigned run;
    int          k;
    logic        over;
    v    = longint'($signed(w.value));
    over = (run_pos >= Depth);
    if (!over) begin
      run_pos++;
      run_prefix += v;
      if (sum_stack[run_height - 1] >= run_prefix) begin
        if (run_height < Depth + 1) begin
          pos_stack[run_height] = run_pos;
          sum_stack[run_height] = run_prefix;
          run_height++;
        end
      end else begin
        // count leading entries whose sum is not below the new prefix
        c = 0;
        for (k = Steps - 1; k >= 0; k--) begin
          stride = 1 << k;
          if (c + stride <= run_height && sum_stack[c + stride - 1] >= run_prefix) c += stride;
        end
        if (c >= run_height) c = run_height - 1;
        run = run_pos - pos_stack[c];
        if (run > run_best) run_best = run;
      end
    end
    r.best_length     = run_best[LenW-1:0];
    r.end_of_sequence = w.last;
    r.overflow        = over;
    if (w.last) clear_tracker();
    return r;
  endfunction

  function automatic int idle_length();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [ValueW-1:0] random_value(value_style_e style);
    int roll;
    roll = $urandom_range(99, 0);
    case (style)
      STYLE_SMALL: return int'($urandom_range(16, 0)) - 8;
      STYLE_FULL:  return $urandom();
      STYLE_DRIFT: begin
        if (roll < 75) return -int'($urandom_range(100, 0));
        return int'($urandom_range(150, 1));
      end
      default: begin
        case (roll % 6)
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] nonpositive_value();
    logic signed [ValueW-1:0] v;
    if ($urandom_range(63, 0) == 0) v = $urandom() | 32'h8000_0000;
    else v = -int'($urandom_range(1000, 0));
    return v;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", msg);
  endfunction

  task automatic send_word(input logic signed [ValueW-1:0] value, input logic last);
    in_word_t w;
    int       gap;
    w.value = value;
    w.last  = last;
    gap     = tx_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    pending_lengths.push_back(track_run(w));
    words_sent++;
    if (pending_lengths[$].overflow) overflow_words++;
    if (int'(pending_lengths[$].best_length) > longest_seen) begin
      longest_seen = int'(pending_lengths[$].best_length);
    end
    if (last) sequences_sent++;
  endtask

  task automatic wait_drained();
    // drop valid so the last word is not taken twice
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // lone elements, both extremes among them
    send_word(5, 1'b1);
    send_word(0, 1'b1);
    send_word(-7, 1'b1);
    send_word(32'sh7fff_ffff, 1'b1);
    send_word(32'sh8000_0000, 1'b1);
    // nothing positive anywhere: length stays zero
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(-5, 1'b0);
    send_word(0, 1'b1);
    // best run sits in the middle, not at the end
    send_word(3, 1'b0);
    send_word(-10, 1'b0);
    send_word(1, 1'b0);
    send_word(1, 1'b0);
    send_word(1, 1'b0);
    send_word(-20, 1'b1);
    // extremes back to back push the prefix past 32 bits
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh7fff_ffff, 1'b1);
    // equal prefix sums
    send_word(-2, 1'b0);
    send_word(2, 1'b0);
    send_word(0, 1'b0);
    send_word(1, 1'b1);
  endtask

  task automatic test_full_stack();
    int i;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // every element pushes, so the stack grows by one entry per word
    for (i = 0; i < 60; i++) send_word(nonpositive_value(), 1'b0);
    send_word($urandom(), 1'b0);
    send_word($urandom(), 1'b0);
    send_word($urandom(), 1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_deep_search();
    int                       i;
    logic signed [ValueW-1:0] v;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (i = 0; i < 100; i++) begin
      if ($urandom_range(49, 0) == 0) v = int'($urandom_range(5000, 1));
      else v = -int'($urandom_range(30, 0));
      send_word(v, 1'b0);
    end
    // lift the prefix above zero: run reaches back to position zero
    send_word(32'sh7fff_ffff, 1'b0);
    send_word($urandom(), 1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_sequences(input int target);
    int           sent;
    int           seq_count;
    int           len;
    int           roll;
    int           i;
    value_style_e style;
    sent      = 0;
    seq_count = 0;
    while (sent < target) begin
      roll  = $urandom_range(99, 0);
      len   = (roll < 70) ? $urandom_range(24, 1) :
              (roll < 95) ? $urandom_range(120, 25) : $urandom_range(400, 121);
      if (len > target - sent) len = target - sent;
      style = value_style_e'($urandom_range(3, 0));
      for (i = 0; i < len; i++) send_word(random_value(style), i == len - 1);
      sent += len;
      seq_count++;
      // hold off the sender until every result is back
      if (seq_count % 8 == 3) wait_drained();
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (rx_idle_on) stall_left = idle_length();
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (pending_lengths.size() == 0) begin
        note_mismatch($sformatf("unexpected result len=%0d eos=%0b ovf=%0b",
                                out_word.best_length, out_word.end_of_sequence,
                                out_word.overflow));
      end else begin
        want = pending_lengths.pop_front();
        results_checked++;
        if (out_word.best_length !== want.best_length ||
            out_word.end_of_sequence !== want.end_of_sequence ||
            out_word.overflow !== want.overflow) begin
          note_mismatch($sformatf(
            "result %0d: expected len=%0d eos=%0b ovf=%0b, got len=%0d eos=%0b ovf=%0b",
            results_checked, want.best_length, want.end_of_sequence, want.overflow,
            out_word.best_length, out_word.end_of_sequence, out_word.overflow));
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_lengths.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clear_tracker();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    wait_drained();
    test_full_stack();
    wait_drained();
    test_deep_search();
    wait_drained();
    test_random_sequences(660);
    @(negedge clk_i);
    in_valid = 1'b0;
    wait_drained();
    repeat (SearchLatency + 10) @(posedge clk_i);
    $display("Sent %0d words in %0d sequences, %0d past the depth limit, longest run %0d",
             words_sent, sequences_sent, overflow_words, longest_seen);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
